@@ src/satcc_pkg.sv @@
// shared types, constants and codes for the 3-sat clause checker and bias classifier
// no dependencies
`default_nettype none

package satcc_pkg;

    localparam int MAX_VARS    = 20;
    localparam int MAX_CLAUSES = 4096;

    localparam int COUNT_W  = 21;
    localparam int VAR_W    = 5;
    localparam int CLIDX_W  = 12;
    localparam int ASSIGN_W = 20;
    localparam int NCL_W    = 13;
    localparam int CFG_W    = 13;
    localparam int CFG_IDX_W = 1;

    // effective variable count, clause address and clause count widths
    localparam int NV_W  = $clog2(MAX_VARS + 1);
    localparam int CL_AW = (MAX_CLAUSES > 1) ? $clog2(MAX_CLAUSES) : 1;
    localparam int CNT_W = $clog2(MAX_CLAUSES + 1);

    // one table word: negation flags above the three variable indices
    localparam int CLV_W = 3 * VAR_W;
    localparam int CL_W  = CLV_W + 3;

    // bias thresholds as exact cross-multiplication weights
    localparam int CMP_W    = COUNT_W + 5;
    localparam int W_FZ_ONE = 20;
    localparam int W_FO_ONE = 20;
    localparam int W_FO_SOL = 19;
    localparam int W_BI_ONE = 5;
    localparam int W_BL_SOL = 2;
    localparam int W_BH_SOL = 3;

    typedef enum logic [1:0] {
        MODE_LOAD     = 2'd0,
        MODE_CHECK    = 2'd1,
        MODE_CLASSIFY = 2'd2,
        MODE_CLEAR    = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        CLS_FROZEN_ZERO = 2'd0,
        CLS_FROZEN_ONE  = 2'd1,
        CLS_BIASED      = 2'd2,
        CLS_FREE        = 2'd3
    } t_var_class;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_VARS    = 1'b0,
        CFG_NUM_CLAUSES = 1'b1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_SCAN = 2'd1,
        ST_EMIT = 2'd2
    } t_state;

    typedef struct packed {
        t_mode               mode;
        logic [CLIDX_W-1:0]  clause_index;
        logic [VAR_W-1:0]    lit_var_a;
        logic [VAR_W-1:0]    lit_var_b;
        logic [VAR_W-1:0]    lit_var_c;
        logic                lit_neg_a;
        logic                lit_neg_b;
        logic                lit_neg_c;
        logic [ASSIGN_W-1:0] assignment;
        logic [VAR_W-1:0]    var_index;
    } t_in_item;

    typedef struct packed {
        logic               satisfied;
        logic [COUNT_W-1:0] solution_count;
        logic [COUNT_W-1:0] ones_count;
        t_var_class         var_class;
    } t_out_item;

    typedef struct packed {
        logic busy;
        logic done;
        logic ok;
    } t_chk_stat;

endpackage

`default_nettype wire

@@ src/sat_clause_checker_bias_classifier.sv @@
// top level: 3-sat clause table, assignment checker and variable bias classifier
// depends on satcc_pkg, satcc_ram, satcc_check, satcc_count
//
//  channel  | signals                          | direction | transfer when
//  ---------+----------------------------------+-----------+-------------------------
//  input    | i_in_valid o_in_ready i_in_data  | in        | i_in_valid & o_in_ready
//  output   | o_out_valid i_out_ready o_out_data| out      | o_out_valid & i_out_ready
//  config   | i_cfg_we i_cfg_idx i_cfg_data    | in        | i_cfg_we
//
// load and clear finish on acceptance, classify passes through ST_EMIT to the output register
// a check makes one table read per clause through the ram port, none with no clauses, then
// the last clause result, the counter update and the output load follow in that order
// the table needs no clearing pass, counters are cleared by reset at once
// a finished result waits in the output register while the next item is taken
// reset is synchronous, active low
`default_nettype none

module sat_clause_checker_bias_classifier (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_ready,
    input  wire satcc_pkg::t_in_item                   i_in_data,
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_ready,
    output satcc_pkg::t_out_item                       o_out_data,
    input  wire logic                                  i_cfg_we,
    input  wire logic [satcc_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire logic [satcc_pkg::CFG_W-1:0]           i_cfg_data
);

    satcc_pkg::t_state              r_state;
    satcc_pkg::t_state              n_state;
    satcc_pkg::t_mode               r_mode;
    logic [satcc_pkg::MAX_VARS-1:0] r_x;
    logic [satcc_pkg::VAR_W-1:0]    r_var;
    logic [satcc_pkg::VAR_W-1:0]    r_num_vars;
    logic [satcc_pkg::NCL_W-1:0]    r_num_clauses;
    logic                           r_out_valid;
    satcc_pkg::t_out_item           r_out;
    satcc_pkg::t_out_item           n_out;

    logic                           accept;
    logic                           out_free;
    logic                           load_out;
    logic                           chk_start;
    logic                           cnt_inc;
    logic                           cnt_clr;
    logic                           ram_we;
    logic [satcc_pkg::NV_W-1:0]     n_eff;
    logic [satcc_pkg::CNT_W-1:0]    m_eff;
    logic [satcc_pkg::MAX_VARS-1:0] x_mask;
    logic [satcc_pkg::MAX_VARS-1:0] x_in;
    logic [satcc_pkg::CL_W-1:0]     ram_wdata;
    logic [satcc_pkg::CL_W-1:0]     ram_rdata;
    logic                           ram_re;
    logic [satcc_pkg::CL_AW-1:0]    ram_raddr;
    satcc_pkg::t_chk_stat           chk_stat;
    logic [satcc_pkg::COUNT_W-1:0]  cnt_total;
    logic [satcc_pkg::COUNT_W-1:0]  cnt_ones;
    satcc_pkg::t_var_class          cnt_class;

    // register values above the table limits act as the limits
    always_comb begin
        if (int'(r_num_vars) > satcc_pkg::MAX_VARS) begin
            n_eff = satcc_pkg::NV_W'(satcc_pkg::MAX_VARS);
        end else begin
            n_eff = satcc_pkg::NV_W'(r_num_vars);
        end
        if (int'(r_num_clauses) > satcc_pkg::MAX_CLAUSES) begin
            m_eff = satcc_pkg::CNT_W'(satcc_pkg::MAX_CLAUSES);
        end else begin
            m_eff = satcc_pkg::CNT_W'(r_num_clauses);
        end
        for (int i = 0; i < satcc_pkg::MAX_VARS; i++) begin
            x_mask[i] = (i < int'(n_eff));
        end
    end

    assign x_in   = satcc_pkg::MAX_VARS'(i_in_data.assignment) & x_mask;
    assign accept = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;

    assign ram_wdata = {i_in_data.lit_neg_c, i_in_data.lit_neg_b, i_in_data.lit_neg_a,
                        i_in_data.lit_var_c, i_in_data.lit_var_b, i_in_data.lit_var_a};
    assign ram_we = accept && (i_in_data.mode == satcc_pkg::MODE_LOAD)
                    && (int'(i_in_data.clause_index) < satcc_pkg::MAX_CLAUSES);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            satcc_pkg::ST_IDLE: begin
                if (accept && i_in_data.mode == satcc_pkg::MODE_CHECK) begin
                    n_state = satcc_pkg::ST_SCAN;
                end else if (accept && i_in_data.mode == satcc_pkg::MODE_CLASSIFY) begin
                    n_state = satcc_pkg::ST_EMIT;
                end
            end
            satcc_pkg::ST_SCAN: begin
                if (chk_stat.done) begin
                    n_state = satcc_pkg::ST_EMIT;
                end
            end
            satcc_pkg::ST_EMIT: begin
                if (out_free) begin
                    n_state = satcc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = satcc_pkg::ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        o_in_ready = 1'b0;
        chk_start  = 1'b0;
        cnt_clr    = 1'b0;
        cnt_inc    = 1'b0;
        load_out   = 1'b0;
        case (r_state)
            satcc_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                chk_start  = i_in_valid && i_in_data.mode == satcc_pkg::MODE_CHECK;
                cnt_clr    = i_in_valid && i_in_data.mode == satcc_pkg::MODE_CLEAR;
            end
            satcc_pkg::ST_SCAN: begin
                cnt_inc = chk_stat.done && chk_stat.ok;
            end
            satcc_pkg::ST_EMIT: begin
                load_out = out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    // result payload
    always_comb begin
        n_out.solution_count = cnt_total;
        case (r_mode)
            satcc_pkg::MODE_CHECK: begin
                n_out.satisfied  = chk_stat.ok;
                n_out.ones_count = '0;
                n_out.var_class  = satcc_pkg::CLS_FROZEN_ZERO;
            end
            default: begin
                n_out.satisfied  = 1'b0;
                n_out.ones_count = cnt_ones;
                n_out.var_class  = cnt_class;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= satcc_pkg::ST_IDLE;
            r_out_valid   <= 1'b0;
            r_num_vars    <= satcc_pkg::VAR_W'(20);
            r_num_clauses <= '0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    satcc_pkg::CFG_NUM_VARS: begin
                        r_num_vars <= i_cfg_data[satcc_pkg::VAR_W-1:0];
                    end
                    satcc_pkg::CFG_NUM_CLAUSES: begin
                        r_num_clauses <= i_cfg_data[satcc_pkg::NCL_W-1:0];
                    end
                    default: begin
                        r_num_vars <= r_num_vars;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode <= i_in_data.mode;
            r_x    <= x_in;
            r_var  <= i_in_data.var_index;
        end
        if (load_out) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    satcc_ram #(
        .WIDTH (satcc_pkg::CL_W),
        .DEPTH (satcc_pkg::MAX_CLAUSES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (satcc_pkg::CL_AW'(i_in_data.clause_index)),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    satcc_check u_check (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (chk_start),
        .i_clauses (m_eff),
        .i_x       (r_x),
        .i_rdata   (ram_rdata),
        .o_re      (ram_re),
        .o_raddr   (ram_raddr),
        .o_stat    (chk_stat)
    );

    satcc_count u_count (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clr   (cnt_clr),
        .i_inc   (cnt_inc),
        .i_x     (r_x),
        .i_var   (r_var),
        .i_n     (n_eff),
        .o_total (cnt_total),
        .o_ones  (cnt_ones),
        .o_class (cnt_class)
    );

endmodule

`default_nettype wire

@@ src/satcc_ram.sv @@
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module satcc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ src/satcc_check.sv @@
// clause scan: reads one clause a cycle from the table and ands the clause results
// depends on satcc_pkg
`default_nettype none

module satcc_check (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_start,
    input  wire logic [satcc_pkg::CNT_W-1:0]          i_clauses,
    input  wire logic [satcc_pkg::MAX_VARS-1:0]       i_x,
    input  wire logic [satcc_pkg::CL_W-1:0]           i_rdata,
    output logic                                      o_re,
    output logic      [satcc_pkg::CL_AW-1:0]          o_raddr,
    output satcc_pkg::t_chk_stat                      o_stat
);

    logic                          r_busy;
    logic                          r_pend;
    logic                          r_ok;
    logic [satcc_pkg::CNT_W-1:0]   r_addr;
    logic                          issue;
    logic                          clause_true;
    logic [31:0]                   x_ext;

    assign issue   = r_busy && (r_addr < i_clauses);
    assign o_re    = issue;
    assign o_raddr = r_addr[satcc_pkg::CL_AW-1:0];
    assign x_ext   = 32'(i_x);

    // any true literal makes the clause true
    always_comb begin
        logic [satcc_pkg::VAR_W-1:0] v;
        clause_true = 1'b0;
        for (int i = 0; i < 3; i++) begin
            v = i_rdata[i*satcc_pkg::VAR_W +: satcc_pkg::VAR_W];
            if (x_ext[v] ^ i_rdata[satcc_pkg::CLV_W + i]) begin
                clause_true = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pend <= 1'b0;
            r_ok   <= 1'b1;
            r_addr <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_pend <= 1'b0;
            r_ok   <= 1'b1;
            r_addr <= '0;
        end else if (r_busy) begin
            r_pend <= issue;
            if (issue) begin
                r_addr <= r_addr + 1'b1;
            end
            if (r_pend && !clause_true) begin
                r_ok <= 1'b0;
            end
            if (!issue && !r_pend) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_busy && !issue && !r_pend;
    assign o_stat.ok   = r_ok;

endmodule

`default_nettype wire

@@ src/satcc_count.sv @@
// solution and per-variable ones counters with the bias classifier
// depends on satcc_pkg
`default_nettype none

module satcc_count (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_clr,
    input  wire logic                                 i_inc,
    input  wire logic [satcc_pkg::MAX_VARS-1:0]       i_x,
    input  wire logic [satcc_pkg::VAR_W-1:0]          i_var,
    input  wire logic [satcc_pkg::NV_W-1:0]           i_n,
    output logic      [satcc_pkg::COUNT_W-1:0]        o_total,
    output logic      [satcc_pkg::COUNT_W-1:0]        o_ones,
    output satcc_pkg::t_var_class                     o_class
);

    localparam logic [satcc_pkg::COUNT_W-1:0] COUNT_MAX = '1;

    logic [satcc_pkg::COUNT_W-1:0] r_total;
    logic [satcc_pkg::COUNT_W-1:0] r_ones [satcc_pkg::MAX_VARS];
    logic [satcc_pkg::COUNT_W-1:0] ones_sel;
    logic [satcc_pkg::CMP_W-1:0]   fz_one;
    logic [satcc_pkg::CMP_W-1:0]   fo_one;
    logic [satcc_pkg::CMP_W-1:0]   fo_sol;
    logic [satcc_pkg::CMP_W-1:0]   bi_one;
    logic [satcc_pkg::CMP_W-1:0]   bl_sol;
    logic [satcc_pkg::CMP_W-1:0]   bh_sol;
    logic [satcc_pkg::CMP_W-1:0]   sols;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_total <= '0;
            for (int i = 0; i < satcc_pkg::MAX_VARS; i++) begin
                r_ones[i] <= '0;
            end
        end else if (i_inc) begin
            if (r_total != COUNT_MAX) begin
                r_total <= r_total + 1'b1;
            end
            for (int i = 0; i < satcc_pkg::MAX_VARS; i++) begin
                if (i_x[i] && r_ones[i] != COUNT_MAX) begin
                    r_ones[i] <= r_ones[i] + 1'b1;
                end
            end
        end
    end

    // variables at or above the active count read as zero
    always_comb begin
        ones_sel = '0;
        for (int i = 0; i < satcc_pkg::MAX_VARS; i++) begin
            if (int'(i_var) == i && i < int'(i_n)) begin
                ones_sel = r_ones[i];
            end
        end
    end

    assign sols   = satcc_pkg::CMP_W'(r_total);
    assign fz_one = satcc_pkg::CMP_W'(ones_sel) * satcc_pkg::CMP_W'(satcc_pkg::W_FZ_ONE);
    assign fo_one = satcc_pkg::CMP_W'(ones_sel) * satcc_pkg::CMP_W'(satcc_pkg::W_FO_ONE);
    assign fo_sol = sols * satcc_pkg::CMP_W'(satcc_pkg::W_FO_SOL);
    assign bi_one = satcc_pkg::CMP_W'(ones_sel) * satcc_pkg::CMP_W'(satcc_pkg::W_BI_ONE);
    assign bl_sol = sols * satcc_pkg::CMP_W'(satcc_pkg::W_BL_SOL);
    assign bh_sol = sols * satcc_pkg::CMP_W'(satcc_pkg::W_BH_SOL);

    always_comb begin
        if (r_total == '0) begin
            o_class = satcc_pkg::CLS_FREE;
        end else if (fz_one <= sols) begin
            o_class = satcc_pkg::CLS_FROZEN_ZERO;
        end else if (fo_one >= fo_sol) begin
            o_class = satcc_pkg::CLS_FROZEN_ONE;
        end else if (bi_one <= bl_sol || bi_one >= bh_sol) begin
            o_class = satcc_pkg::CLS_BIASED;
        end else begin
            o_class = satcc_pkg::CLS_FREE;
        end
    end

    assign o_total = r_total;
    assign o_ones  = ones_sel;

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// self-checking testbench for sat_clause_checker_bias_classifier: clause loads, checks,
// bias classification and counter clears against an in-bench model of the counters and table
// depends on satcc_pkg and the block itself
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import satcc_pkg::*;

    localparam int unsigned CYCLE_LIMIT    = 2_000_000;
    localparam int unsigned SHOW_LIMIT     = 200;
    localparam int unsigned PREFIX_CLAUSES = 300;
    localparam int unsigned RANDOM_ITEMS   = 1000;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    t_in_item  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_data;
    logic      cfg_we    = 1'b0;
    t_cfg_reg  cfg_idx   = CFG_NUM_VARS;
    logic [CFG_W-1:0] cfg_data = '0;

    sat_clause_checker_bias_classifier dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    initial forever #5 clk = ~clk;

    // shadow of the clause table, counters and registers
    logic [CLV_W-1:0]   tbl_vars [MAX_CLAUSES];
    logic [2:0]         tbl_negs [MAX_CLAUSES];
    logic [COUNT_W-1:0] sol_total = '0;
    logic [COUNT_W-1:0] ones_tally [MAX_VARS] = '{default: '0};
    logic [4:0]         nv_sh  = 5'd20;
    logic [NCL_W-1:0]   ncl_sh = '0;

    t_in_item  items_to_send [$];
    t_out_item answers_due [$];

    logic [ASSIGN_W-1:0] planted = '0;
    bit          tx_burst = 1'b0;
    bit          rx_burst = 1'b0;
    bit          stall_req = 1'b0;
    bit          stall_done = 1'b0;
    bit          take;
    int unsigned tx_wait, rx_wait, hold_left;
    int unsigned queued_items, results_seen, mismatches, cycles;
    int unsigned n_loads, n_checks, n_sat, n_classifies, n_clears;
    int unsigned cls_seen [4];
    int unsigned bias_marks [11] = '{0, 1, 2, 8, 9, 10, 11, 12, 18, 19, 20};

    function automatic int unsigned active_vars();
        return (nv_sh > MAX_VARS) ? MAX_VARS : nv_sh;
    endfunction

    function automatic logic [ASSIGN_W-1:0] var_mask(int unsigned n);
        return {ASSIGN_W{1'b1}} >> (ASSIGN_W - n);
    endfunction

    function automatic logic [COUNT_W-1:0] bump(logic [COUNT_W-1:0] c);
        return (c == {COUNT_W{1'b1}}) ? c : c + 1'b1;
    endfunction

    function automatic bit formula_holds(logic [31:0] x);
        int unsigned m;
        bit any;
        logic [4:0] v;
        m = (ncl_sh > MAX_CLAUSES) ? MAX_CLAUSES : ncl_sh;
        for (int unsigned k = 0; k < m; k++) begin
            any = 1'b0;
            for (int i = 0; i < 3; i++) begin
                v = tbl_vars[k][VAR_W*i +: VAR_W];
                if (x[v] ^ tbl_negs[k][i]) any = 1'b1;
            end
            if (!any) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic t_var_class bias_class(logic [COUNT_W-1:0] ones, logic [COUNT_W-1:0] sols);
        longint unsigned o, s;
        o = ones;
        s = sols;
        if (s == 0) return CLS_FREE;
        if (20 * o <= s) return CLS_FROZEN_ZERO;
        if (20 * o >= 19 * s) return CLS_FROZEN_ONE;
        if (5 * o <= 2 * s || 5 * o >= 3 * s) return CLS_BIASED;
        return CLS_FREE;
    endfunction

    // apply one accepted item to the shadow state and queue the answer of a check or classify
    task automatic absorb_item(t_in_item it);
        t_out_item ans;
        int unsigned n;
        logic [31:0] x;
        n = active_vars();
        ans = '0;
        case (it.mode)
            MODE_LOAD: begin
                tbl_vars[it.clause_index] = {it.lit_var_c, it.lit_var_b, it.lit_var_a};
                tbl_negs[it.clause_index] = {it.lit_neg_c, it.lit_neg_b, it.lit_neg_a};
                n_loads++;
            end
            MODE_CLEAR: begin
                sol_total = '0;
                for (int i = 0; i < MAX_VARS; i++) ones_tally[i] = '0;
                n_clears++;
            end
            MODE_CHECK: begin
                x = {12'b0, it.assignment & var_mask(n)};
                ans.satisfied = formula_holds(x);
                if (ans.satisfied) begin
                    sol_total = bump(sol_total);
                    for (int unsigned i = 0; i < n; i++) begin
                        if (x[i]) ones_tally[i] = bump(ones_tally[i]);
                    end
                    n_sat++;
                end
                ans.solution_count = sol_total;
                ans.var_class = CLS_FROZEN_ZERO;
                answers_due.push_back(ans);
                n_checks++;
            end
            MODE_CLASSIFY: begin
                ans.solution_count = sol_total;
                if (it.var_index < n) ans.ones_count = ones_tally[it.var_index];
                ans.var_class = bias_class(ans.ones_count, sol_total);
                cls_seen[ans.var_class]++;
                answers_due.push_back(ans);
                n_classifies++;
            end
        endcase
    endtask

    function automatic int unsigned draw_gap(bit burst);
        if (burst || $urandom_range(0, 3) == 0) return 0;
        return $urandom_range(0, 18);
    endfunction

    task automatic match_field(string tag, logic [COUNT_W-1:0] want_v,
                               logic [COUNT_W-1:0] got_v);
        if (want_v !== got_v) begin
            mismatches++;
            if (mismatches <= SHOW_LIMIT)
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, tag, want_v, got_v);
        end
    endtask

    // input side
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            tx_wait = 0;
        end else begin
            take = in_valid && in_ready;
            if (take) begin
                absorb_item(in_data);
                tx_wait = draw_gap(tx_burst);
            end
            if (!in_valid || take) begin
                if (tx_wait > 0) begin
                    tx_wait--;
                    in_valid <= 1'b0;
                end else if (items_to_send.size() != 0) begin
                    in_data  <= items_to_send.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // output side
    t_out_item want, got;

    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
            rx_wait = 0;
        end else begin
            if (out_valid && out_ready) begin
                got = out_data;
                results_seen++;
                if (answers_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= SHOW_LIMIT)
                        $display("%0t: unexpected result, expected none, got %h", $time, got);
                end else begin
                    want = answers_due.pop_front();
                    match_field("satisfied", want.satisfied, got.satisfied);
                    match_field("solution_count", want.solution_count, got.solution_count);
                    match_field("ones_count", want.ones_count, got.ones_count);
                    match_field("var_class", want.var_class, got.var_class);
                end
                rx_wait = draw_gap(rx_burst);
            end
            if (stall_req && !stall_done) begin
                stall_done = 1'b1;
                hold_left = 500;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d answers outstanding", cycles,
                     answers_due.size());
            $display("Verification failed");
            $finish;
        end
    end

    function automatic t_in_item blank_item(t_mode m);
        t_in_item it;
        logic [63:0] r;
        r = {$urandom, $urandom};
        it = r[$bits(t_in_item)-1:0];
        it.mode = m;
        return it;
    endfunction

    // clause with random literals, optionally kept true under the planted assignment
    function automatic t_in_item clause_item(logic [CLIDX_W-1:0] slot, bit keep_planted);
        t_in_item it;
        logic [31:0] p;
        it = blank_item(MODE_LOAD);
        it.clause_index = slot;
        it.lit_var_a = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(0, 31))
                                                   : 5'($urandom_range(0, 19));
        it.lit_var_b = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(0, 31))
                                                   : 5'($urandom_range(0, 19));
        it.lit_var_c = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(0, 31))
                                                   : 5'($urandom_range(0, 19));
        if (keep_planted) begin
            p = {12'b0, planted & var_mask(active_vars())};
            it.lit_neg_a = ~p[it.lit_var_a];
        end
        return it;
    endfunction

    function automatic t_in_item load_item(logic [CLIDX_W-1:0] slot, logic [VAR_W-1:0] va,
                                           logic [VAR_W-1:0] vb, logic [VAR_W-1:0] vc,
                                           logic [2:0] negs);
        t_in_item it;
        it = blank_item(MODE_LOAD);
        it.clause_index = slot;
        it.lit_var_a = va;
        it.lit_var_b = vb;
        it.lit_var_c = vc;
        {it.lit_neg_c, it.lit_neg_b, it.lit_neg_a} = negs;
        return it;
    endfunction

    function automatic t_in_item check_item(logic [ASSIGN_W-1:0] a);
        t_in_item it;
        it = blank_item(MODE_CHECK);
        it.assignment = a;
        return it;
    endfunction

    function automatic t_in_item classify_item(logic [VAR_W-1:0] v);
        t_in_item it;
        it = blank_item(MODE_CLASSIFY);
        it.var_index = v;
        return it;
    endfunction

    task automatic queue_item(t_in_item it);
        items_to_send.push_back(it);
        queued_items++;
    endtask

    task automatic wait_idle();
        do @(negedge clk);
        while (items_to_send.size() != 0 || in_valid || answers_due.size() != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(t_cfg_reg which, logic [CFG_W-1:0] value);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= which;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (which == CFG_NUM_VARS) nv_sh = value[4:0];
        else ncl_sh = value;
    endtask

    initial begin
        int unsigned base, phase, nvv, ncl, r, targets [20];
        logic [ASSIGN_W-1:0] a;
        logic [CLIDX_W-1:0] slot;
        bit bias_run;
        t_in_item it;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // no solutions yet, empty formula, out-of-range variable, clear
        queue_item(classify_item(5'd5));
        queue_item(check_item('1));
        queue_item(check_item('0));
        queue_item(classify_item(5'd0));
        queue_item(classify_item(5'd31));
        queue_item(blank_item(MODE_CLEAR));
        queue_item(classify_item(5'd19));
        // small table: plain, all negated, literal above the variable range, tautology
        queue_item(load_item(12'd0, 5'd0, 5'd1, 5'd2, 3'b000));
        queue_item(load_item(12'd1, 5'd0, 5'd1, 5'd2, 3'b111));
        queue_item(load_item(12'd2, 5'd19, 5'd25, 5'd31, 3'b100));
        queue_item(load_item(12'd3, 5'd19, 5'd19, 5'd3, 3'b001));
        queue_item(load_item('1, 5'd31, 5'd31, 5'd31, 3'b111));
        wait_idle();
        write_reg(CFG_NUM_CLAUSES, 13'd4);
        queue_item(check_item(20'h00000));
        queue_item(check_item(20'h00001));
        queue_item(check_item(20'h00007));
        queue_item(check_item(20'hFFFFF));
        wait_idle();
        // assignment bits above num_vars read as zero
        write_reg(CFG_NUM_VARS, 13'h1FE2);
        queue_item(check_item(20'h00007));
        queue_item(classify_item(5'd1));
        queue_item(classify_item(5'd2));
        wait_idle();
        write_reg(CFG_NUM_VARS, 13'd31);
        queue_item(check_item(20'hFFFFE));
        wait_idle();
        write_reg(CFG_NUM_VARS, 13'd0);
        write_reg(CFG_NUM_CLAUSES, 13'd0);
        queue_item(check_item(20'hFFFFF));
        queue_item(classify_item(5'd0));
        wait_idle();

        // clause prefix for the random phases, kept satisfiable by the planted assignment
        write_reg(CFG_NUM_VARS, 13'd20);
        planted = 20'($urandom);
        tx_burst = 1'b1;
        for (int unsigned s = 0; s < PREFIX_CLAUSES; s++) queue_item(clause_item(12'(s), 1'b1));
        wait_idle();
        tx_burst = 1'b0;
        write_reg(CFG_NUM_CLAUSES, 13'(PREFIX_CLAUSES));
        queue_item(check_item(planted));
        queue_item(check_item(planted ^ (20'd1 << $urandom_range(0, 19))));
        queue_item(check_item(20'($urandom)));
        queue_item(classify_item(5'($urandom_range(0, 19))));
        wait_idle();

        base = queued_items;
        phase = 0;
        while ((queued_items - base) < RANDOM_ITEMS || results_seen < 48) begin
            phase++;
            tx_burst = ($urandom_range(0, 4) == 0);
            rx_burst = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 3) == 0) planted = 20'($urandom);
            case ($urandom_range(0, 7))
                0: nvv = $urandom_range(0, 3);
                1: nvv = 31;
                2: nvv = $urandom_range(0, 31);
                default: nvv = 20;
            endcase
            case ($urandom_range(0, 7))
                0: ncl = 0;
                1: ncl = 1;
                2: ncl = $urandom_range(100, PREFIX_CLAUSES);
                default: ncl = $urandom_range(2, 40);
            endcase
            bias_run = (phase != 3) && ($urandom_range(0, 3) == 0);
            if (bias_run) ncl = 0;
            if ($urandom_range(0, 1) == 0) begin
                write_reg(CFG_NUM_VARS, {8'($urandom), 5'(nvv)});
                write_reg(CFG_NUM_CLAUSES, 13'(ncl));
            end else begin
                write_reg(CFG_NUM_CLAUSES, 13'(ncl));
                write_reg(CFG_NUM_VARS, {8'($urandom), 5'(nvv)});
            end
            // hold the output off so the block backs up onto its input
            if (phase == 3) begin
                stall_req = 1'b1;
                tx_burst = 1'b1;
            end
            if (bias_run) begin
                // twenty solutions with ones counts mostly on the class boundaries
                for (int k = 0; k < 20; k++) begin
                    targets[k] = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 20)
                                                             : bias_marks[$urandom_range(0, 10)];
                end
                queue_item(blank_item(MODE_CLEAR));
                for (int unsigned j = 0; j < 20; j++) begin
                    a = '0;
                    for (int k = 0; k < 20; k++) a[k] = (j < targets[k]);
                    queue_item(check_item(a));
                end
                for (int k = 0; k < 20; k++) queue_item(classify_item(5'(k)));
                queue_item(blank_item(MODE_CLASSIFY));
                queue_item(blank_item(MODE_CLASSIFY));
            end else begin
                for (int i = 0; i < 40; i++) begin
                    r = $urandom_range(0, 99);
                    if (r < 25) begin
                        slot = (ncl != 0 && $urandom_range(0, 3) != 0)
                             ? 12'($urandom_range(0, ncl - 1)) : 12'($urandom_range(0, 4095));
                        queue_item(clause_item(slot, $urandom_range(0, 4) != 0));
                    end else if (r < 65) begin
                        case ($urandom_range(0, 3))
                            0: a = planted;
                            1: a = planted ^ (20'd1 << $urandom_range(0, 19));
                            default: a = 20'($urandom);
                        endcase
                        queue_item(check_item(a));
                    end else if (r < 93) begin
                        it = blank_item(MODE_CLASSIFY);
                        if ($urandom_range(0, 4) != 0) it.var_index = 5'($urandom_range(0, 19));
                        queue_item(it);
                    end else begin
                        queue_item(blank_item(MODE_CLEAR));
                    end
                end
            end
            wait_idle();
        end

        repeat (20) @(posedge clk);
        $display("%0d transfers in: %0d loads, %0d checks (%0d satisfied), %0d classifies, %0d clears",
                 n_loads + n_checks + n_classifies + n_clears, n_loads, n_checks, n_sat,
                 n_classifies, n_clears);
        $display("%0d results compared over %0d phases, classes zero/one/biased/free %0d/%0d/%0d/%0d, %0d mismatches",
                 results_seen, phase, cls_seen[CLS_FROZEN_ZERO], cls_seen[CLS_FROZEN_ONE],
                 cls_seen[CLS_BIASED], cls_seen[CLS_FREE], mismatches);
        if (mismatches == 0 && answers_due.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ sim.f @@
src/satcc_pkg.sv
src/satcc_ram.sv
src/satcc_check.sv
src/satcc_count.sv
src/sat_clause_checker_bias_classifier.sv
tb/testbench.sv
